### src/i2cwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the write-only I2C master.
// Used by the line sequencer, the top level and the bench; depends on nothing else.
package i2cwm_pkg;

	// Configuration register indexes (byte address is 4 * index).
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DEVICE_ADDRESS  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COMMAND_CONTROL = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DATA_CONTROL    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_HOLD_LENGTH     = 2'd3;

	// Register values after reset.
	localparam logic [7:0]  RST_DEVICE_ADDRESS  = 8'h78;
	localparam logic [7:0]  RST_COMMAND_CONTROL = 8'h00;
	localparam logic [7:0]  RST_DATA_CONTROL    = 8'h40;
	localparam logic [15:0] RST_HOLD_LENGTH     = 16'd16;

	// One input item.
	typedef struct packed {
		logic [7:0] payload;
		logic       mode;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	// Framing bytes the sequencer needs from the register file.
	typedef struct packed {
		logic [7:0] device_address;
		logic [7:0] command_control;
		logic [7:0] data_control;
	} frame_cfg_t;

	// One line segment.
	typedef struct packed {
		logic clock_line;
		logic data_line;
		logic end_of_run;
	} seg_t;

endpackage

### src/i2cwm_seq.sv
`timescale 1ns / 1ps
// Line sequencer: turns one item into start, byte and stop segments using a
// single shift register, and holds the resulting segment in an output register.
// Depends on i2cwm_pkg.
module i2cwm_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  i2cwm_pkg::item_t      item,
	input  i2cwm_pkg::frame_cfg_t cfg,
	output logic                  seg_valid,
	input  logic                  seg_ready,
	output i2cwm_pkg::seg_t       seg
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_BYTE  = 2'd2;
	localparam logic [1:0] ST_STOP  = 2'd3;

	localparam logic [1:0] BYTE_ADDR = 2'd0;
	localparam logic [1:0] BYTE_CTRL = 2'd1;
	localparam logic [1:0] BYTE_DATA = 2'd2;

	localparam logic [3:0] ACK_BIT = 4'd8;

	logic [1:0] state_q;
	logic [1:0] sub_q;
	logic [1:0] byte_sel_q;
	logic [3:0] bit_q;
	logic       half_q;
	logic [7:0] shift_q;
	logic [7:0] payload_q;
	logic       mode_q;
	logic       last_q;
	logic       open_q;

	logic            out_valid_q;
	i2cwm_pkg::seg_t out_seg_q;

	logic            accept;
	logic            advance;
	logic            gen_valid;
	i2cwm_pkg::seg_t gen_seg;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign advance    = !out_valid_q || seg_ready;
	assign gen_valid  = (state_q != ST_IDLE);

	// Segment for the current step.
	always_comb begin
		gen_seg = '0;
		case (state_q)
			ST_START: begin
				gen_seg.clock_line = 1'b1;
				gen_seg.data_line  = (sub_q == 2'd0);
			end
			ST_BYTE: begin
				gen_seg.clock_line = half_q;
				gen_seg.data_line  = (bit_q == ACK_BIT) ? 1'b1 : shift_q[7];
				gen_seg.end_of_run = half_q && (bit_q == ACK_BIT) &&
					(byte_sel_q == BYTE_DATA) && !last_q;
			end
			ST_STOP: begin
				gen_seg.clock_line = (sub_q != 2'd0);
				gen_seg.data_line  = (sub_q == 2'd2);
				gen_seg.end_of_run = (sub_q == 2'd2);
			end
			default: gen_seg = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sub_q      <= 2'd0;
			byte_sel_q <= BYTE_ADDR;
			bit_q      <= 4'd0;
			half_q     <= 1'b0;
			open_q     <= 1'b0;
		end else if (accept) begin
			sub_q  <= 2'd0;
			bit_q  <= 4'd0;
			half_q <= 1'b0;
			if (item.first_byte || !open_q) begin
				state_q <= ST_START;
			end else begin
				state_q    <= ST_BYTE;
				byte_sel_q <= BYTE_DATA;
			end
		end else if (gen_valid && advance) begin
			case (state_q)
				ST_START: begin
					if (sub_q == 2'd0) begin
						sub_q <= 2'd1;
					end else begin
						state_q    <= ST_BYTE;
						byte_sel_q <= BYTE_ADDR;
						open_q     <= 1'b1;
					end
				end
				ST_BYTE: begin
					if (!half_q) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (bit_q != ACK_BIT) begin
							bit_q <= bit_q + 4'd1;
						end else begin
							bit_q <= 4'd0;
							case (byte_sel_q)
								BYTE_ADDR: byte_sel_q <= BYTE_CTRL;
								BYTE_CTRL: byte_sel_q <= BYTE_DATA;
								default: begin
									sub_q   <= 2'd0;
									state_q <= last_q ? ST_STOP : ST_IDLE;
								end
							endcase
						end
					end
				end
				ST_STOP: begin
					if (sub_q == 2'd2) begin
						state_q <= ST_IDLE;
						open_q  <= 1'b0;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item fields and the shared shift register, which carries the address, control and payload bytes.
	always_ff @(posedge clk) begin
		if (accept) begin
			payload_q <= item.payload;
			mode_q    <= item.mode;
			last_q    <= item.last_byte;
			shift_q   <= item.payload;
		end else if (gen_valid && advance) begin
			if (state_q == ST_START && sub_q != 2'd0) begin
				shift_q <= cfg.device_address;
			end else if (state_q == ST_BYTE && half_q) begin
				if (bit_q != ACK_BIT) begin
					shift_q <= {shift_q[6:0], 1'b0};
				end else if (byte_sel_q == BYTE_ADDR) begin
					shift_q <= mode_q ? cfg.data_control : cfg.command_control;
				end else if (byte_sel_q == BYTE_CTRL) begin
					shift_q <= payload_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= gen_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gen_valid) begin
			out_seg_q <= gen_seg;
		end
	end

	assign seg_valid = out_valid_q;
	assign seg       = out_seg_q;

endmodule

### src/i2c_write_only_master.sv
`timescale 1ns / 1ps
// An item's first segment passes the sequencer state register, then the output register.
// An item gives 18 to 59 segments, one per cycle while m_tready is high; the single line
// sequencer and its shift register mean no new item is taken while one is being worked through.
// s_tready stays low from acceptance until the item's final segment is in the output register.
// Reset (arst_n low) closes any transaction, empties the output register and restores registers.
// Top level: APB register file plus the line sequencer (i2cwm_seq); uses i2cwm_pkg.
module i2c_write_only_master (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] payload
	input  logic [1:0]  s_tuser,   // [0] mode, [1] first_byte
	input  logic        s_tlast,   // last_byte
	// Result items, one per line segment.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] clock_line, [1] data_line, [7:2] zero
	output logic        m_tlast    // end_of_run
);

	logic [7:0]  device_address_q;
	logic [7:0]  command_control_q;
	logic [7:0]  data_control_q;
	logic [15:0] hold_length_q;

	logic [i2cwm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                            reg_wr;

	i2cwm_pkg::item_t      item;
	i2cwm_pkg::frame_cfg_t cfg;
	i2cwm_pkg::seg_t       seg;

	// The port never stalls; a write lands on the access cycle.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q  <= i2cwm_pkg::RST_DEVICE_ADDRESS;
			command_control_q <= i2cwm_pkg::RST_COMMAND_CONTROL;
			data_control_q    <= i2cwm_pkg::RST_DATA_CONTROL;
			hold_length_q     <= i2cwm_pkg::RST_HOLD_LENGTH;
		end else if (reg_wr) begin
			case (reg_idx)
				i2cwm_pkg::REG_DEVICE_ADDRESS:  device_address_q  <= pwdata[7:0];
				i2cwm_pkg::REG_COMMAND_CONTROL: command_control_q <= pwdata[7:0];
				i2cwm_pkg::REG_DATA_CONTROL:    data_control_q    <= pwdata[7:0];
				i2cwm_pkg::REG_HOLD_LENGTH:     hold_length_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back. The hold length is kept for software that paces the pins;
	// the segment stream itself does not depend on it.
	always_comb begin
		case (reg_idx)
			i2cwm_pkg::REG_DEVICE_ADDRESS:  prdata = {24'd0, device_address_q};
			i2cwm_pkg::REG_COMMAND_CONTROL: prdata = {24'd0, command_control_q};
			i2cwm_pkg::REG_DATA_CONTROL:    prdata = {24'd0, data_control_q};
			i2cwm_pkg::REG_HOLD_LENGTH:     prdata = {16'd0, hold_length_q};
			default:                        prdata = 32'd0;
		endcase
	end

	assign item.payload    = s_tdata;
	assign item.mode       = s_tuser[0];
	assign item.first_byte = s_tuser[1];
	assign item.last_byte  = s_tlast;

	assign cfg.device_address  = device_address_q;
	assign cfg.command_control = command_control_q;
	assign cfg.data_control    = data_control_q;

	// The sequencer walks start, address, control, payload and stop phases
	// through one shift register, one segment per cycle while m_tready is high.
	i2cwm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item       (item),
		.cfg        (cfg),
		.seg_valid  (m_tvalid),
		.seg_ready  (m_tready),
		.seg        (seg)
	);

	assign m_tdata = {6'd0, seg.data_line, seg.clock_line};
	assign m_tlast = seg.end_of_run;

endmodule

### src/i2cwm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the write-only I2C master, bound to the top level.
// Depends only on the top level's ports.
module i2cwm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled segment stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("segment withdrawn while stalled");

	// A stalled segment keeps its line levels and end mark.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("segment changed while stalled");

	// Taking an item drops s_tready, so no second item is taken back to back.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted during a run");

	// When the block is ready for a new item, any pending segment ends a run.
	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && m_tvalid |-> m_tlast)
		else $error("ready for an item with a run still in progress");

endmodule

bind i2c_write_only_master i2cwm_checker u_i2cwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### bench/i2cwm_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the write-only I2C master: follows register writes and accepted items,
// works out the line segments each item must produce and compares them in order.
// Depends on i2cwm_pkg for the item and segment types and the register map.
module i2cwm_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	output int          mismatches,
	output int          pending,
	output int          items_seen,
	output int          segs_seen
);

	// Own copy of the register file and of the bus state.
	logic [7:0]  addr_byte;
	logic [7:0]  cmd_ctl;
	logic [7:0]  dat_ctl;
	logic        bus_open;

	i2cwm_pkg::seg_t owed_segments[$];
	int   err_cnt;
	int   item_cnt;
	int   seg_cnt;

	function automatic void owe_segment(input logic scl, input logic sda);
		i2cwm_pkg::seg_t s;
		s.clock_line = scl;
		s.data_line  = sda;
		s.end_of_run = 1'b0;
		owed_segments.push_back(s);
	endfunction

	function automatic void owe_byte(input logic [7:0] b);
		for (int k = 7; k >= 0; k--) begin
			owe_segment(1'b0, b[k]);
			owe_segment(1'b1, b[k]);
		end
		// Acknowledge clock with SDA released; the acknowledge is not looked at.
		owe_segment(1'b0, 1'b1);
		owe_segment(1'b1, 1'b1);
	endfunction

	function automatic void queue_line_segments(input i2cwm_pkg::item_t it);
		i2cwm_pkg::seg_t tail;
		if (it.first_byte || !bus_open) begin
			owe_segment(1'b1, 1'b1);
			owe_segment(1'b1, 1'b0);
			owe_byte(addr_byte);
			owe_byte(it.mode ? dat_ctl : cmd_ctl);
			bus_open = 1'b1;
		end
		owe_byte(it.payload);
		if (it.last_byte) begin
			owe_segment(1'b0, 1'b0);
			owe_segment(1'b1, 1'b0);
			owe_segment(1'b1, 1'b1);
			bus_open = 1'b0;
		end
		tail = owed_segments.pop_back();
		tail.end_of_run = 1'b1;
		owed_segments.push_back(tail);
	endfunction

	function automatic void flag(input string field, input logic [7:0] want,
			input logic [7:0] got);
		err_cnt++;
		$error("segment %0d %s: expected %0h, actual %0h", seg_cnt, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		i2cwm_pkg::item_t it;
		i2cwm_pkg::seg_t  want;
		if (!arst_n) begin
			addr_byte  = i2cwm_pkg::RST_DEVICE_ADDRESS;
			cmd_ctl    = i2cwm_pkg::RST_COMMAND_CONTROL;
			dat_ctl    = i2cwm_pkg::RST_DATA_CONTROL;
			bus_open   = 1'b0;
			owed_segments.delete();
			err_cnt    = 0;
			item_cnt   = 0;
			seg_cnt    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					i2cwm_pkg::REG_DEVICE_ADDRESS:  addr_byte = pwdata[7:0];
					i2cwm_pkg::REG_COMMAND_CONTROL: cmd_ctl   = pwdata[7:0];
					i2cwm_pkg::REG_DATA_CONTROL:    dat_ctl   = pwdata[7:0];
					// The hold length only paces the pins; segments do not depend on it.
					i2cwm_pkg::REG_HOLD_LENGTH: ;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				it.payload    = s_tdata;
				it.mode       = s_tuser[0];
				it.first_byte = s_tuser[1];
				it.last_byte  = s_tlast;
				queue_line_segments(it);
				item_cnt++;
			end
			if (m_tvalid && m_tready) begin
				if (owed_segments.size() == 0) begin
					err_cnt++;
					$error("segment %0d arrived with nothing expected", seg_cnt);
				end else begin
					want = owed_segments.pop_front();
					if (m_tdata[0] !== want.clock_line)
						flag("clock_line", {7'd0, want.clock_line}, {7'd0, m_tdata[0]});
					if (m_tdata[1] !== want.data_line)
						flag("data_line", {7'd0, want.data_line}, {7'd0, m_tdata[1]});
					if (m_tlast !== want.end_of_run)
						flag("end_of_run", {7'd0, want.end_of_run}, {7'd0, m_tlast});
					if (m_tdata[7:2] !== 6'd0)
						flag("tdata padding", 8'h00, {2'd0, m_tdata[7:2]});
				end
				seg_cnt++;
			end
		end
		mismatches <= err_cnt;
		pending    <= owed_segments.size();
		items_seen <= item_cnt;
		segs_seen  <= seg_cnt;
	end

endmodule

### bench/tb_i2c_write_only_master.sv
`timescale 1ns / 1ps
// Top of the testbench for the write-only I2C master: clock, reset, register setup and
// item traffic; the frame checker beside the block does the prediction and comparison.
// Depends on i2cwm_pkg, i2c_write_only_master and i2cwm_frame_checker.
module tb_i2c_write_only_master;

	// Receiver behavior, picked afresh each time a random stretch runs out.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] payload
	logic [1:0]  s_tuser;   // [0] mode, [1] first_byte
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;   // [0] clock_line, [1] data_line, [7:2] zero
	logic        m_tlast;   // end_of_run

	int mismatches;
	int pending;
	int items_seen;
	int segs_seen;

	// Sender burst bookkeeping and the number of register settings run through.
	int burst_left;
	int settings_run;

	rx_style_t rx_style = RX_ALWAYS;
	int        rx_left = 0;

	i2c_write_only_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	i2cwm_frame_checker u_frame_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pending    (pending),
		.items_seen (items_seen),
		.segs_seen  (segs_seen)
	);

	always #4 clk = ~clk;

	// The receiver switches between taking every segment, light and heavy random
	// stalls, and a fixed pattern where it is ready while the stretch counter modulo 16 is below 3.
	// Each style lasts a random stretch so stalls land on every part of a frame.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 3));
			rx_left  <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_style)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    m_tready <= ($urandom_range(0, 3) == 0);
			RX_PERIODIC: m_tready <= (rx_left % 16 < 3);
			default:     m_tready <= 1'b1;
		endcase
	end

	// One register write: setup cycle, then access cycle until pready is seen.
	// The bus is then left idle so that the next write raises psel in a
	// later time step.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwdata  <= $urandom;
		@(posedge clk);
	endtask

	// Values are full 32-bit words, so the upper bits beyond each register
	// must be dropped by the block.
	task automatic apply_setting(input logic [31:0] addr_val, input logic [31:0] cmd_val,
			input logic [31:0] dat_val, input logic [31:0] hold_val);
		write_reg(i2cwm_pkg::REG_DEVICE_ADDRESS, addr_val);
		write_reg(i2cwm_pkg::REG_COMMAND_CONTROL, cmd_val);
		write_reg(i2cwm_pkg::REG_DATA_CONTROL, dat_val);
		write_reg(i2cwm_pkg::REG_HOLD_LENGTH, hold_val);
		settings_run++;
	endtask

	// Offer one item and wait for it to be taken. The sender works in bursts:
	// when a burst ends, or when the phase is over (park), tvalid drops and the
	// data lines carry junk; a gap of random length follows a finished burst unless parked.
	task automatic push_item(input logic [7:0] payload, input logic mode,
			input logic first_byte, input logic last_byte, input logic park);
		s_tvalid <= 1'b1;
		s_tdata  <= payload;
		s_tuser  <= {first_byte, mode};
		s_tlast  <= last_byte;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0 || park) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			s_tuser  <= 2'($urandom);
			s_tlast  <= 1'($urandom);
			if (!park)
				repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
				: $urandom_range(1, 4);
		end
	endtask

	// Wait until every expected segment has come back. The first edge lets the
	// checker account for an item taken at the edge just passed.
	task automatic drain_segments();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly well-formed transactions (open, a few body bytes, close), the rest
	// items with random framing flags. Mode on non-opening items is random and
	// must be ignored by the block.
	task automatic random_traffic(input int count);
		int sent;
		int body;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 85) begin
				body = $urandom_range(0, 5);
				for (int k = 0; k <= body && sent < count; k++) begin
					push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), k == 0,
						k == body, sent + 1 == count);
					sent++;
				end
			end else begin
				push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sent + 1 == count);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = 4'd0;
		pwdata       = 32'd0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'd0;
		s_tuser      = 2'd0;
		s_tlast      = 1'b0;
		burst_left   = 0;
		settings_run = 1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run on the register values left by reset.
		push_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);   // open with the command control byte
		push_item(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);   // plain body byte
		push_item(8'hA5, 1'b1, 1'b0, 1'b1, 1'b0);   // close; mode has no say here
		push_item(8'h5A, 1'b1, 1'b0, 1'b1, 1'b0);   // last on an idle bus opens and closes
		push_item(8'h01, 1'b1, 1'b1, 1'b0, 1'b0);   // open with the data control byte
		push_item(8'h80, 1'b0, 1'b1, 1'b0, 1'b0);   // repeated start while open
		push_item(8'h7F, 1'b1, 1'b1, 1'b1, 1'b0);   // repeated start that also closes
		push_item(8'hFE, 1'b1, 1'b0, 1'b0, 1'b0);   // no first flag, but the bus is idle
		push_item(8'hC3, 1'b0, 1'b0, 1'b0, 1'b0);   // mode flips mid-transaction, ignored
		push_item(8'h3C, 1'b0, 1'b0, 1'b1, 1'b0);
		push_item(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);   // single-item transactions
		push_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
		drain_segments();

		// Extremes of the registers, then a zero hold length, then random settings.
		apply_setting(32'h0000_00FF, 32'h0000_00FF, 32'h0000_0000, 32'h0000_0001);
		random_traffic(36);
		drain_segments();
		apply_setting(32'hFFFF_FF00, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_traffic(36);
		drain_segments();
		apply_setting($urandom, $urandom, $urandom, 32'hABCD_0000);
		random_traffic(36);
		drain_segments();
		repeat (3) begin
			apply_setting($urandom, $urandom, $urandom, $urandom);
			random_traffic(36);
			drain_segments();
		end

		// Give the block time to show any stray segment after the last one.
		repeat (8) @(posedge clk);

		$display("Run covered %0d items and %0d line segments under %0d register settings,",
			items_seen, segs_seen, settings_run);
		$display("with repeated starts, opens without the first flag and single-item frames.");
		if (mismatches == 0 && pending == 0) begin
			$display("tb_i2c_write_only_master passed");
		end else begin
			$display("tb_i2c_write_only_master failed");
		end
		$finish;
	end

	// The watchdog stops a run that has not finished long after the slowest legal run would have.
	initial begin
		#10_000_000;
		$error("run did not finish in time, %0d segments still expected", pending);
		$display("tb_i2c_write_only_master failed");
		$finish;
	end

endmodule
